// File: hdl/playfair_stream_cipher_top_macros.svh
// Assertion macros for the checker file of the playfair stream cipher.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef PLAYFAIR_STREAM_CIPHER_TOP_MACROS_SVH
`define PLAYFAIR_STREAM_CIPHER_TOP_MACROS_SVH

// Same-cycle implication.
`define PFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pfc_pkg.sv
// Shared types, constants and key-square helpers for the playfair stream cipher.
// No dependencies; every other RTL file refers to it by scoped names.
package pfc_pkg;

  localparam int SQ_DIM = 5;
  localparam int CODE_W = 5;
  localparam int ROW_W  = $clog2(SQ_DIM);
  localparam int KROW_W = SQ_DIM * CODE_W;

  localparam logic [CODE_W-1:0] LETTER_X = 5'd23;
  localparam logic [CODE_W-1:0] LETTER_I = 5'd8;
  localparam logic [CODE_W-1:0] LETTER_J = 5'd9;
  localparam logic [CODE_W-1:0] LETTER_Q = 5'd16;

  localparam logic [7:0] ASCII_A     = 8'd65;
  localparam logic [7:0] ASCII_Z     = 8'd90;
  localparam logic [7:0] ASCII_LOW_A = 8'd97;
  localparam logic [7:0] ASCII_LOW_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Config register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_DECRYPT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MERGE_I_J    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_ROW0     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_ROW1     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_ROW2     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_ROW3     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_ROW4     = 3'd6;

  localparam logic [KROW_W-1:0] KEY_ROW0_RST = 25'd4294688;
  localparam logic [KROW_W-1:0] KEY_ROW1_RST = 25'd10755269;
  localparam logic [KROW_W-1:0] KEY_ROW2_RST = 25'd16201099;
  localparam logic [KROW_W-1:0] KEY_ROW3_RST = 25'd21613104;
  localparam logic [KROW_W-1:0] KEY_ROW4_RST = 25'd27025109;

  // Digraph queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [SQ_DIM-1:0][KROW_W-1:0] key_sq_t;

  typedef struct packed {
    logic    mode_decrypt;
    logic    merge_i_j;
    key_sq_t key;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } sq_rc_t;

  typedef struct packed {
    logic   found;
    sq_rc_t rc;
  } sq_pos_t;

  typedef struct packed {
    sq_rc_t a;
    sq_rc_t b;
  } digraph_t;

  // One queue entry holds every digraph, as square positions, caused by one input byte.
  typedef struct packed {
    logic     two;
    digraph_t dg0;
    digraph_t dg1;
    logic     msg_end;
  } q_entry_t;

  // First match in row order wins: scan backwards so the earliest hit is last.
  function automatic sq_pos_t sq_find(key_sq_t key, logic [CODE_W-1:0] letter);
    sq_pos_t p;
    p = '0;
    for (int y = SQ_DIM - 1; y >= 0; y--) begin
      for (int x = SQ_DIM - 1; x >= 0; x--) begin
        if (key[y][CODE_W*x +: CODE_W] == letter) begin
          p.found  = 1'b1;
          p.rc.row = ROW_W'(y);
          p.rc.col = ROW_W'(x);
        end
      end
    end
    return p;
  endfunction

  function automatic logic [CODE_W-1:0] sq_cell(key_sq_t key, sq_rc_t rc);
    return key[rc.row][CODE_W*rc.col +: CODE_W];
  endfunction

  // One step with wrap, forward or backward.
  function automatic logic [ROW_W-1:0] sq_shift(logic [ROW_W-1:0] v, logic back);
    logic [ROW_W-1:0] r;
    if (back) begin
      r = (v == '0) ? ROW_W'(SQ_DIM - 1) : v - 1'b1;
    end else begin
      r = (v == ROW_W'(SQ_DIM - 1)) ? '0 : v + 1'b1;
    end
    return r;
  endfunction

endpackage

// File: hdl/pfc_front.sv
// Front end: byte classification, X insertion, digraph pairing and square lookup.
// Depends on pfc_pkg; pushes one entry per byte that yields cipher letters.
module pfc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  pfc_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  logic [7:0]       in_data,
  input  logic             in_last,
  output logic             in_ready,
  input  logic             q_full,
  output logic             q_push,
  output pfc_pkg::q_entry_t q_entry
);

  logic                        opv_r, opv_nxt;
  logic [pfc_pkg::CODE_W-1:0]  opl_r, opl_nxt;
  logic                        dv_r, dv_nxt;
  logic [pfc_pkg::CODE_W-1:0]  dl_r, dl_nxt;
  logic                        accept;

  logic [7:0]                  ch;
  logic [7:0]                  diff;
  logic                        keep;
  logic [pfc_pkg::CODE_W-1:0]  letter;
  logic                        ins_x;
  logic                        have0;
  logic                        dv;
  logic [pfc_pkg::CODE_W-1:0]  dl;
  pfc_pkg::sq_pos_t            dl_pos;
  pfc_pkg::sq_pos_t            pos_x;
  pfc_pkg::sq_pos_t            pos_l;
  logic [2:0]                  fv;
  logic [2:0][pfc_pkg::CODE_W-1:0] fl;
  pfc_pkg::sq_pos_t [2:0]      fp;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    ch = in_data;
    if (ch inside {[pfc_pkg::ASCII_LOW_A:pfc_pkg::ASCII_LOW_Z]}) begin
      ch = ch - pfc_pkg::CASE_OFFSET;
    end
    keep   = ch inside {[pfc_pkg::ASCII_A:pfc_pkg::ASCII_Z]};
    diff   = ch - pfc_pkg::ASCII_A;
    letter = diff[pfc_pkg::CODE_W-1:0];
    if (keep) begin
      if (letter == pfc_pkg::LETTER_J && cfg.merge_i_j) begin
        letter = pfc_pkg::LETTER_I;
      end else if (letter == pfc_pkg::LETTER_Q && !cfg.merge_i_j) begin
        keep = 1'b0;
      end
    end

    // Original-pair tracking, encrypt only
    ins_x   = keep && !cfg.mode_decrypt && opv_r && (opl_r == letter);
    opv_nxt = opv_r;
    opl_nxt = opl_r;
    if (keep && !cfg.mode_decrypt) begin
      if (!opv_r) begin
        opv_nxt = 1'b1;
        opl_nxt = letter;
      end else begin
        opv_nxt = 1'b0;
      end
    end

    pos_x = pfc_pkg::sq_find(cfg.key, pfc_pkg::LETTER_X);
    pos_l = pfc_pkg::sq_find(cfg.key, letter);

    // Feed order: inserted X, the letter, end-of-message pad X
    fv    = {1'b0, keep, ins_x};
    fl    = {pfc_pkg::LETTER_X, letter, pfc_pkg::LETTER_X};
    fp    = {pos_x, pos_l, pos_x};

    dv     = dv_r;
    dl     = dl_r;
    dl_pos = pfc_pkg::sq_find(cfg.key, dl_r);
    have0  = 1'b0;
    q_entry = '0;
    q_entry.msg_end = in_last;
    for (int k = 0; k < 3; k++) begin
      if (k == 2) begin
        fv[k] = in_last && dv;
      end
      if (fv[k]) begin
        if (dv) begin
          dv = 1'b0;
          // pair with a letter missing from the square gives nothing
          if (dl_pos.found && fp[k].found) begin
            if (!have0) begin
              q_entry.dg0.a = dl_pos.rc;
              q_entry.dg0.b = fp[k].rc;
              have0 = 1'b1;
            end else begin
              q_entry.dg1.a = dl_pos.rc;
              q_entry.dg1.b = fp[k].rc;
              q_entry.two   = 1'b1;
            end
          end
        end else begin
          dv     = 1'b1;
          dl     = fl[k];
          dl_pos = fp[k];
        end
      end
    end

    dv_nxt = dv;
    dl_nxt = dl;
    if (in_last) begin
      opv_nxt = 1'b0;
      opl_nxt = '0;
      dv_nxt  = 1'b0;
      dl_nxt  = '0;
    end
  end

  assign q_push = accept && have0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opv_r <= 1'b0;
      opl_r <= '0;
      dv_r  <= 1'b0;
      dl_r  <= '0;
    end else if (accept) begin
      opv_r <= opv_nxt;
      opl_r <= opl_nxt;
      dv_r  <= dv_nxt;
      dl_r  <= dl_nxt;
    end
  end

endmodule

// File: hdl/pfc_queue.sv
// Short FIFO of digraph entries between front and back ends.
// Depends on pfc_pkg for the entry type and depth.
module pfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pfc_pkg::q_entry_t wr_entry,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output pfc_pkg::q_entry_t rd_entry
);

  pfc_pkg::q_entry_t          mem_r [pfc_pkg::QDEPTH];
  logic [pfc_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [pfc_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign full     = (cnt_r == pfc_pkg::QCNT_W'(pfc_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// File: hdl/pfc_back.sv
// Back end: expands queued digraphs into cipher letters, one per cycle while the
// output is not stalled. Depends on pfc_pkg; drives the registered output stage.
module pfc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pfc_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  pfc_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_data,
  output logic              out_last,
  output logic              out_user
);

  logic [1:0]                 step_r;
  logic                       out_valid_r;
  logic [pfc_pkg::CODE_W-1:0] letter_r;
  logic                       last_r, user_r;
  logic                       adv, last_step;
  pfc_pkg::digraph_t          dg;
  pfc_pkg::sq_rc_t            mine, rc;
  logic [pfc_pkg::CODE_W-1:0] sq_code;

  assign adv       = !q_empty && (!out_valid_r || out_ready);
  assign last_step = (step_r == {q_head.two, 1'b1});
  assign q_pop     = adv && last_step;

  always_comb begin
    dg   = step_r[1] ? q_head.dg1 : q_head.dg0;
    mine = step_r[0] ? dg.b : dg.a;
    rc   = mine;
    if (dg.a.col == dg.b.col) begin
      rc.row = pfc_pkg::sq_shift(mine.row, cfg.mode_decrypt);
    end else if (dg.a.row == dg.b.row) begin
      rc.col = pfc_pkg::sq_shift(mine.col, cfg.mode_decrypt);
    end else begin
      rc.col = step_r[0] ? dg.a.col : dg.b.col;
    end
    sq_code = pfc_pkg::sq_cell(cfg.key, rc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        step_r      <= last_step ? 2'd0 : step_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      letter_r <= sq_code;
      last_r   <= last_step;
      user_r   <= last_step && q_head.msg_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {{(8 - pfc_pkg::CODE_W){1'b0}}, letter_r};
  assign out_last  = last_r;
  assign out_user  = user_r;

endmodule

// File: hdl/playfair_stream_cipher_top.sv
// Playfair stream cipher: ASCII bytes in, enciphered letter codes out.
// Usage:
//   in_*  : one text byte per transaction; in_tlast marks the final byte of a message,
//           which pads an odd leftover letter with X and clears the pairing state.
//   out_* : one cipher letter (A=0..Z=25) per transaction; out_tlast marks the last
//           letter caused by one input byte, out_tuser the last letter of a message.
//   cfg_* : write-only register port (mode, I/J merge, five key-square rows); write
//           only while no transaction is in flight.
// Path: an accepted byte's digraphs are written into the queue; the back end then
//   registers each of its letters in the output register, from which it leaves.
// Throughput: the front end takes one byte per cycle while the four-entry digraph
//   queue has room; the back end emits one letter per cycle while out_tready is
//   high, and a byte causes 0 to 4 letters (about 2 on ordinary text).
// Reset: synchronous active-low rst_n restores the default key square, encrypt mode
//   with I/J merging, and empties the queue and all pending letters.
// Stall: out_tready low holds the output register; the queue keeps absorbing bytes
//   until full, after which in_tready drops.
// Depends on pfc_pkg, pfc_front, pfc_queue and pfc_back.
module playfair_stream_cipher_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // slave stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,  // [7:0] text_byte
  input  logic                             in_tlast,  // message_end
  // master stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata, // [4:0] cipher_letter, [7:5] zero
  output logic                             out_tlast, // run_last
  output logic                             out_tuser, // [0] message_done
  // config write port
  input  logic                             cfg_we,
  input  logic [pfc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pfc_pkg::KROW_W-1:0]       cfg_wdata
);

  pfc_pkg::cfg_t     cfg_r;
  pfc_pkg::q_entry_t push_entry, head_entry;
  logic              q_push, q_pop, q_full, q_empty;

  // Config registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_decrypt <= 1'b0;
      cfg_r.merge_i_j    <= 1'b1;
      cfg_r.key[0]       <= pfc_pkg::KEY_ROW0_RST;
      cfg_r.key[1]       <= pfc_pkg::KEY_ROW1_RST;
      cfg_r.key[2]       <= pfc_pkg::KEY_ROW2_RST;
      cfg_r.key[3]       <= pfc_pkg::KEY_ROW3_RST;
      cfg_r.key[4]       <= pfc_pkg::KEY_ROW4_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pfc_pkg::REG_MODE_DECRYPT: cfg_r.mode_decrypt <= cfg_wdata[0];
        pfc_pkg::REG_MERGE_I_J:    cfg_r.merge_i_j    <= cfg_wdata[0];
        pfc_pkg::REG_KEY_ROW0:     cfg_r.key[0]       <= cfg_wdata;
        pfc_pkg::REG_KEY_ROW1:     cfg_r.key[1]       <= cfg_wdata;
        pfc_pkg::REG_KEY_ROW2:     cfg_r.key[2]       <= cfg_wdata;
        pfc_pkg::REG_KEY_ROW3:     cfg_r.key[3]       <= cfg_wdata;
        pfc_pkg::REG_KEY_ROW4:     cfg_r.key[4]       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front: classify bytes, form digraphs, locate them in the square
  pfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  // Decouples byte intake from letter output
  pfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (push_entry),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .rd_entry (head_entry)
  );

  // Back: shift/swap in the square, one letter per cycle while out_tready allows
  pfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (head_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_user  (out_tuser)
  );

endmodule

// File: hdl/pfc_checker.sv
// Port-level checks for the playfair stream cipher, bound to the top level.
// Depends on playfair_stream_cipher_top_macros.svh.
`include "playfair_stream_cipher_top_macros.svh"

module pfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  logic       stalled;
  logic [9:0] out_bus;

  assign stalled = out_tvalid && !out_tready;
  assign out_bus = {out_tdata, out_tlast, out_tuser};

  // stalled output holds
  `PFC_ASSERT_NXT(a_out_hold, stalled, out_tvalid && $stable(out_bus), "stalled output moved")

  // message end always closes a byte's run
  `PFC_ASSERT_IMP(a_done_is_last, out_tvalid && out_tuser, out_tlast, "done without last")

  // letter codes stay in five bits
  `PFC_ASSERT_IMP(a_code_pad, out_tvalid, out_tdata[7:5] == 3'b000, "tdata padding not zero")

  // queue is empty right after reset, so input is ready
  `PFC_ASSERT_IMP(a_ready_after_rst, $rose(rst_n), in_tready, "not ready after reset")

endmodule

bind playfair_stream_cipher_top pfc_checker u_pfc_checker (.*);

// File: bench/tb.sv
// Self-checking testbench for playfair_stream_cipher_top.
// Needs pfc_pkg and the cipher RTL; a built-in letter predictor checks every
// output transaction.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog. The limit is ample for the slowest legal run.
  localparam int WATCHDOG_NS  = 200000;
  localparam int DRAIN_CYCLES = 20;    // settle time once the last letter is out
  localparam int PHASE_ITEMS  = 65;    // letters per random configuration phase
  localparam int NUM_PHASES   = 6;

  // One expected output transaction
  typedef struct packed {
    logic [pfc_pkg::CODE_W-1:0] letter;
    logic                       run_last;
    logic                       done;
  } cipher_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = '0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;
  logic                           out_tlast;
  logic                           out_tuser;
  logic                           cfg_we = 1'b0;
  logic [pfc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [pfc_pkg::KROW_W-1:0]     cfg_wdata = '0;

  playfair_stream_cipher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cipher predictor: shadow configuration plus the two pending-letter states.
  // ---------------------------------------------------------------------------
  logic                       mode_dec;
  logic                       merge_ij;
  logic [pfc_pkg::KROW_W-1:0] square_row [pfc_pkg::SQ_DIM];
  logic                       pair_open;     // first letter of an original pair seen
  logic [pfc_pkg::CODE_W-1:0] pair_first;
  logic                       dg_open;       // first letter of a digraph waiting
  logic [pfc_pkg::CODE_W-1:0] dg_first;

  cipher_result_t             expected_letters [$];
  logic [pfc_pkg::CODE_W-1:0] byte_letters [$];   // letters caused by the byte in hand

  int fail_count   = 0;
  int in_idle_pct  = 10;
  int out_idle_pct = 10;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void reset_predictor();
    mode_dec      = 1'b0;
    merge_ij      = 1'b1;
    square_row[0] = pfc_pkg::KEY_ROW0_RST;
    square_row[1] = pfc_pkg::KEY_ROW1_RST;
    square_row[2] = pfc_pkg::KEY_ROW2_RST;
    square_row[3] = pfc_pkg::KEY_ROW3_RST;
    square_row[4] = pfc_pkg::KEY_ROW4_RST;
    pair_open     = 1'b0;
    pair_first    = '0;
    dg_open       = 1'b0;
    dg_first      = '0;
  endfunction

  function automatic logic [pfc_pkg::CODE_W-1:0] square_cell(input int r, input int c);
    return square_row[r][pfc_pkg::CODE_W*c +: pfc_pkg::CODE_W];
  endfunction

  // First hit in row order wins, so repeated codes resolve to the earliest cell.
  function automatic bit locate(input logic [pfc_pkg::CODE_W-1:0] code,
                                output int r, output int c);
    bit hit;
    hit = 1'b0;
    r = 0;
    c = 0;
    for (int y = 0; y < pfc_pkg::SQ_DIM; y++) begin
      for (int x = 0; x < pfc_pkg::SQ_DIM; x++) begin
        if (!hit && square_cell(y, x) == code) begin
          hit = 1'b1;
          r = y;
          c = x;
        end
      end
    end
    return hit;
  endfunction

  function automatic void encipher_pair(input logic [pfc_pkg::CODE_W-1:0] p,
                                        input logic [pfc_pkg::CODE_W-1:0] q);
    int ra, ca, rb, cb, s;
    s = mode_dec ? pfc_pkg::SQ_DIM - 1 : 1;
    // a letter missing from the square silences the whole digraph
    if (!locate(p, ra, ca) || !locate(q, rb, cb)) return;
    if (ca == cb) begin
      byte_letters.push_back(square_cell((ra + s) % pfc_pkg::SQ_DIM, ca));
      byte_letters.push_back(square_cell((rb + s) % pfc_pkg::SQ_DIM, cb));
    end else if (ra == rb) begin
      byte_letters.push_back(square_cell(ra, (ca + s) % pfc_pkg::SQ_DIM));
      byte_letters.push_back(square_cell(rb, (cb + s) % pfc_pkg::SQ_DIM));
    end else begin
      byte_letters.push_back(square_cell(ra, cb));
      byte_letters.push_back(square_cell(rb, ca));
    end
  endfunction

  function automatic void feed_digraph(input logic [pfc_pkg::CODE_W-1:0] code);
    if (!dg_open) begin
      dg_open  = 1'b1;
      dg_first = code;
    end else begin
      dg_open = 1'b0;
      encipher_pair(dg_first, code);
    end
  endfunction

  // Work out the letters caused by one accepted byte and queue them.
  function automatic void predict_cipher(input logic [7:0] text, input logic msg_end);
    logic [7:0]                 ch;
    logic [7:0]                 offs;
    logic                       keep;
    logic [pfc_pkg::CODE_W-1:0] code;
    cipher_result_t             r;
    byte_letters.delete();
    ch = text;
    if (ch >= pfc_pkg::ASCII_LOW_A && ch <= pfc_pkg::ASCII_LOW_Z)
      ch = ch - pfc_pkg::CASE_OFFSET;
    keep = (ch >= pfc_pkg::ASCII_A && ch <= pfc_pkg::ASCII_Z);
    offs = ch - pfc_pkg::ASCII_A;
    code = offs[pfc_pkg::CODE_W-1:0];
    if (keep) begin
      if (code == pfc_pkg::LETTER_J && merge_ij) code = pfc_pkg::LETTER_I;
      else if (code == pfc_pkg::LETTER_Q && !merge_ij) keep = 1'b0;
    end
    if (keep) begin
      if (mode_dec) begin
        // decrypt leaves the original-pair state alone
        feed_digraph(code);
      end else if (!pair_open) begin
        pair_open  = 1'b1;
        pair_first = code;
        feed_digraph(code);
      end else begin
        pair_open = 1'b0;
        if (pair_first == code) feed_digraph(pfc_pkg::LETTER_X);
        feed_digraph(code);
      end
    end
    if (msg_end) begin
      if (dg_open) feed_digraph(pfc_pkg::LETTER_X);
      pair_open  = 1'b0;
      pair_first = '0;
      dg_open    = 1'b0;
      dg_first   = '0;
    end
    foreach (byte_letters[i]) begin
      r.letter   = byte_letters[i];
      r.run_last = (i == byte_letters.size() - 1);
      r.done     = r.run_last && msg_end;
      expected_letters.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure at the falling edge, check at the rising.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cipher_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_letters.size() == 0) begin
        note_failure($sformatf("unexpected letter: tdata=%0d tlast=%0b tuser=%0b",
                               out_tdata, out_tlast, out_tuser));
      end else begin
        want = expected_letters.pop_front();
        if (out_tdata !== {3'b000, want.letter} || out_tlast !== want.run_last ||
            out_tuser !== want.done) begin
          note_failure($sformatf("letter mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 want.letter, want.run_last, want.done,
                                 out_tdata, out_tlast, out_tuser));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Drive one byte transaction with a random gap ahead of it; predict on acceptance.
  task automatic send_byte(input logic [7:0] text, input logic msg_end);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = text;
    in_tlast  = msg_end;
    do @(posedge clk); while (!in_tready);
    predict_cipher(text, msg_end);
  endtask

  task automatic send_text(input string txt, input bit end_msg);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i], end_msg && i == txt.len() - 1);
  endtask

  // Stop the input and let every outstanding letter come out, plus bytes
  // that cause none and may still be in flight.
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes only ever happen on an idle block.
  task automatic write_reg(input logic [pfc_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [pfc_pkg::KROW_W-1:0] value);
    drain_pipeline();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      pfc_pkg::REG_MODE_DECRYPT: mode_dec = value[0];
      pfc_pkg::REG_MERGE_I_J:    merge_ij = value[0];
      pfc_pkg::REG_KEY_ROW0:     square_row[0] = value;
      pfc_pkg::REG_KEY_ROW1:     square_row[1] = value;
      pfc_pkg::REG_KEY_ROW2:     square_row[2] = value;
      pfc_pkg::REG_KEY_ROW3:     square_row[3] = value;
      pfc_pkg::REG_KEY_ROW4:     square_row[4] = value;
      default: ;
    endcase
  endtask

  // Shuffled square; one of the 26 codes is left out (often J). With
  // irregular set, a few cells get arbitrary codes: repeats and codes above Z.
  task automatic load_square(input bit irregular);
    logic [pfc_pkg::CODE_W-1:0] codes [26];
    logic [pfc_pkg::CODE_W-1:0] t;
    logic [pfc_pkg::KROW_W-1:0] row;
    int j;
    for (int i = 0; i < 26; i++) codes[i] = pfc_pkg::CODE_W'(i);
    for (int i = 25; i > 0; i--) begin
      j = $urandom_range(i);
      t = codes[i];
      codes[i] = codes[j];
      codes[j] = t;
    end
    if ($urandom_range(1)) begin
      for (int i = 0; i < 25; i++) begin
        if (codes[i] == pfc_pkg::LETTER_J) begin
          codes[i]  = codes[25];
          codes[25] = pfc_pkg::LETTER_J;
        end
      end
    end
    if (irregular) begin
      repeat (5) codes[$urandom_range(24)] = pfc_pkg::CODE_W'($urandom_range(31));
    end
    for (int r = 0; r < pfc_pkg::SQ_DIM; r++) begin
      for (int c = 0; c < pfc_pkg::SQ_DIM; c++)
        row[pfc_pkg::CODE_W*c +: pfc_pkg::CODE_W] = codes[pfc_pkg::SQ_DIM*r + c];
      write_reg(pfc_pkg::REG_KEY_ROW0 + pfc_pkg::CFG_ADDR_W'(r), row);
    end
  endtask

  // Mostly letters of either case with frequent repeats (to hit equal pairs),
  // some arbitrary bytes; the last byte closes the message. Returns letters sent.
  task automatic send_random_message(output int letters);
    int len, pick;
    logic [7:0] ch, prev;
    letters = 0;
    prev = pfc_pkg::ASCII_A;
    len = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        ch = 8'($urandom_range(255));
      end else begin
        letters++;
        if (pick < 35) begin
          ch = prev;
        end else begin
          ch = pfc_pkg::ASCII_A + 8'($urandom_range(25));
          if ($urandom_range(1)) ch = ch + pfc_pkg::CASE_OFFSET;
        end
      end
      send_byte(ch, i == len - 1);
      prev = ch;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset square, encrypt with I/J merge: doubled letters, padding, byte extremes.
  task automatic test_default_square();
    send_text("Balloon", 1'b1);      // X inside equal pairs, odd letter padded
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("@[{", 1'b0);          // neighbors of both letter ranges
    send_byte(8'h60, 1'b0);
    send_text("aZjJ", 1'b1);         // both cases, J folds into an equal I pair
    send_byte("!", 1'b1);            // message end with nothing pending: no letter
  endtask

  // Q dropped without merging (J then missing from the square); decrypt mode.
  task automatic test_letter_filtering();
    write_reg(pfc_pkg::REG_MERGE_I_J, pfc_pkg::KROW_W'(1'b0));
    send_text("Qaj", 1'b1);          // A/J digraph gives nothing, no message_done
    send_text("qcat", 1'b1);
    write_reg(pfc_pkg::REG_MODE_DECRYPT, pfc_pkg::KROW_W'(1'b1));
    send_text("eeGd", 1'b1);         // no X inserted when decrypting
  endtask

  // Square with a row of all-ones codes and a row of repeated A.
  task automatic test_irregular_square();
    write_reg(pfc_pkg::REG_KEY_ROW0, {pfc_pkg::KROW_W{1'b1}});
    write_reg(pfc_pkg::REG_KEY_ROW1, '0);
    send_text("AL", 1'b1);           // decrypt up into row 0 reads out code 31
    write_reg(pfc_pkg::REG_MODE_DECRYPT, pfc_pkg::KROW_W'(1'b0));
    send_text("AB", 1'b1);           // B missing: end of message with no letter
  endtask

  // Several configurations; one phase runs with no idling on either side.
  task automatic test_random_messages();
    int total, n;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(pfc_pkg::REG_MODE_DECRYPT,
                pfc_pkg::KROW_W'((p < 4) ? p[0] : 1'($urandom_range(1))));
      write_reg(pfc_pkg::REG_MERGE_I_J,
                pfc_pkg::KROW_W'((p < 4) ? p[1] : 1'($urandom_range(1))));
      load_square(p == NUM_PHASES - 1);
      in_idle_pct  = (p == 4) ? 0 : 10;
      out_idle_pct = (p == 4) ? 0 : 10;
      total = 0;
      while (total < PHASE_ITEMS) begin
        send_random_message(n);
        total += n;
      end
    end
    in_idle_pct  = 10;
    out_idle_pct = 10;
  endtask

  initial begin
    int waited;
    reset_predictor();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_square();
    test_letter_filtering();
    test_irregular_square();
    test_random_messages();

    // final drain, bounded so a missing letter is reported rather than hung on
    @(negedge clk);
    in_tvalid = 1'b0;
    waited = 0;
    while (expected_letters.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_letters.size() != 0)
      note_failure($sformatf("%0d expected letters never arrived", expected_letters.size()));
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("FAIL");
    $finish;
  end

endmodule

// File: playfair_stream_cipher_top.f
+incdir+hdl
hdl/pfc_pkg.sv
hdl/pfc_front.sv
hdl/pfc_queue.sv
hdl/pfc_back.sv
hdl/playfair_stream_cipher_top.sv
hdl/pfc_checker.sv
bench/tb.sv
